[design/binding_store_latest_match_assert.svh]
// assertion macros for the binding store block
// expects signals clk and rst_n in the scope where a macro is used
`ifndef BINDING_STORE_LATEST_MATCH_ASSERT_SVH
`define BINDING_STORE_LATEST_MATCH_ASSERT_SVH

// same-cycle implication
`define BSLM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BSLM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/bslm_pkg.sv]
// shared types and codes for the binding store block
// no dependencies
package bslm_pkg;

    typedef enum logic
    {
        OP_BIND   = 1'b0,
        OP_LOOKUP = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed
    {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

endpackage

[design/bslm_mem.sv]
// key and value memory, one write port and one registered read port
// depends on bslm_pkg
module bslm_mem #(
    parameter int DEPTH      = 32,
    parameter int VALUE_BITS = 16,
    parameter int KEY_BITS   = 4,
    parameter int AW         = 5
) (
    input  logic                  clk,
    input  bslm_pkg::mem_ctl_t    mem_ctl,
    input  logic [AW-1:0]         wr_addr,
    input  logic [KEY_BITS-1:0]   wr_key,
    input  logic [VALUE_BITS-1:0] wr_val,
    input  logic [AW-1:0]         rd_addr,
    output logic [KEY_BITS-1:0]   rd_key,
    output logic [VALUE_BITS-1:0] rd_val
);
    import bslm_pkg::*;

    logic [KEY_BITS-1:0]   key_mem [DEPTH];
    logic [VALUE_BITS-1:0] val_mem [DEPTH];
    logic [KEY_BITS-1:0]   rd_key_reg;
    logic [VALUE_BITS-1:0] rd_val_reg;

    always_ff @(posedge clk)
    begin
        if (mem_ctl.wr_en)
        begin
            key_mem[wr_addr] <= wr_key;
            val_mem[wr_addr] <= wr_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_ctl.rd_en)
        begin
            rd_key_reg <= key_mem[rd_addr];
            rd_val_reg <= val_mem[rd_addr];
        end
    end

    assign rd_key = rd_key_reg;
    assign rd_val = rd_val_reg;

endmodule

[design/bslm_ctrl.sv]
// sequencer: entry count, newest-first scan and output register
// depends on bslm_pkg
module bslm_ctrl #(
    parameter int DEPTH      = 32,
    parameter int VALUE_BITS = 16,
    parameter int KEY_BITS   = 4,
    parameter int AW         = 5,
    parameter int CW         = 6
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  operation,
    input  logic [KEY_BITS-1:0]   key,
    input  logic [VALUE_BITS-1:0] value,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [VALUE_BITS-1:0] result_value,
    output logic                  store_full,
    output bslm_pkg::mem_ctl_t    mem_ctl,
    output logic [AW-1:0]         wr_addr,
    output logic [AW-1:0]         rd_addr,
    input  logic [KEY_BITS-1:0]   rd_key,
    input  logic [VALUE_BITS-1:0] rd_val
);
    import bslm_pkg::*;

    state_t                state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [AW-1:0]         ptr_reg, ptr_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [VALUE_BITS-1:0] res_val_reg, res_val_next;
    logic                  res_full_reg, res_full_next;
    logic                  out_valid_reg;
    logic [VALUE_BITS-1:0] out_val_reg;
    logic                  out_full_reg;
    logic                  accept;
    logic                  is_full;
    logic                  is_empty;
    logic                  hit;
    logic                  out_free;
    logic                  out_load;

    assign accept   = in_valid && !in_stall;
    assign is_full  = (count_reg == CW'(DEPTH));
    assign is_empty = (count_reg == '0);
    assign hit      = (rd_key == key_reg);
    assign out_free = !out_valid_reg || !out_stall;
    assign out_load = (state_reg == ST_DONE) && out_free;
    assign in_stall = (state_reg != ST_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if ((operation == OP_LOOKUP) && !is_empty)
                        state_next = ST_SCAN;
                    else
                        state_next = ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (hit || (ptr_reg == '0))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        count_next    = count_reg;
        ptr_next      = ptr_reg;
        key_next      = key_reg;
        val_next      = val_reg;
        res_val_next  = res_val_reg;
        res_full_next = res_full_reg;
        mem_ctl       = '0;
        wr_addr       = count_reg[AW-1:0];
        rd_addr       = ptr_reg - AW'(1);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    key_next = key;
                    val_next = value;
                    if (operation == OP_BIND)
                    begin
                        res_val_next = '0;
                        if (is_full)
                        begin
                            res_full_next = 1'b1;
                        end
                        else
                        begin
                            res_full_next = 1'b0;
                            mem_ctl.wr_en = 1'b1;
                            count_next    = count_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        res_full_next = 1'b0;
                        res_val_next  = value;
                        if (!is_empty)
                        begin
                            rd_addr       = AW'(count_reg - CW'(1));
                            mem_ctl.rd_en = 1'b1;
                            ptr_next      = AW'(count_reg - CW'(1));
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    res_val_next = rd_val | val_reg;
                end
                else if (ptr_reg != '0)
                begin
                    mem_ctl.rd_en = 1'b1;
                    ptr_next      = ptr_reg - AW'(1);
                end
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg      <= ptr_next;
        key_reg      <= key_next;
        val_reg      <= val_next;
        res_val_reg  <= res_val_next;
        res_full_reg <= res_full_next;
        if (out_load)
        begin
            out_val_reg  <= res_val_reg;
            out_full_reg <= res_full_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_value = out_val_reg;
    assign store_full   = out_full_reg;

endmodule

[design/binding_store_latest_match.sv]
// binding store top level: append-only key/value store with latest-match lookup
// depends on bslm_pkg, bslm_mem, bslm_ctrl and binding_store_latest_match_assert.svh
//
// usage
// - input channel (in_valid / in_stall) carries operation, key, value
// - operation bind appends (key, value) at the next free entry; result_value is 0
//   and store_full is 1 when the store already holds DEPTH entries (pair dropped)
// - operation lookup scans the stored entries newest first, one memory read per
//   cycle, and returns the newest matching value ORed with value, or value alone
// - output channel (out_valid / out_stall) gives one transaction per input transaction
// - a lookup reads the entries up to and including the match (none on an empty
//   store, at most the entry count)
// - one item at a time; the next transaction is taken the cycle after the result
//   enters the output register; a lookup reads the entries through the single
//   read port of the store memory
// - reset empties the store at once (entry count cleared, no clearing pass)
// - while the receiver stalls, the result waits in the output register; a new
//   input is still taken and worked on, then held until the register frees
module binding_store_latest_match #(
    parameter int DEPTH      = 32,
    parameter int VALUE_BITS = 16,
    parameter int KEY_BITS   = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  operation,
    input  logic [KEY_BITS-1:0]   key,
    input  logic [VALUE_BITS-1:0] value,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [VALUE_BITS-1:0] result_value,
    output logic                  store_full
);
    import bslm_pkg::*;

    `include "binding_store_latest_match_assert.svh"

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    mem_ctl_t              mem_ctl;
    logic [AW-1:0]         wr_addr;
    logic [AW-1:0]         rd_addr;
    logic [KEY_BITS-1:0]   rd_key;
    logic [VALUE_BITS-1:0] rd_val;
    logic                  bind_accept;

    assign bind_accept = in_valid && !in_stall && (operation == OP_BIND);

    bslm_ctrl #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS),
        .KEY_BITS   (KEY_BITS),
        .AW         (AW),
        .CW         (CW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .key          (key),
        .value        (value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_value (result_value),
        .store_full   (store_full),
        .mem_ctl      (mem_ctl),
        .wr_addr      (wr_addr),
        .rd_addr      (rd_addr),
        .rd_key       (rd_key),
        .rd_val       (rd_val)
    );

    bslm_mem #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS),
        .KEY_BITS   (KEY_BITS),
        .AW         (AW)
    ) u_mem (
        .clk     (clk),
        .mem_ctl (mem_ctl),
        .wr_addr (wr_addr),
        .wr_key  (key),
        .wr_val  (value),
        .rd_addr (rd_addr),
        .rd_key  (rd_key),
        .rd_val  (rd_val)
    );

    `BSLM_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted while busy")
    `BSLM_ASSERT_NOW(a_no_rw_overlap, mem_ctl.wr_en, !mem_ctl.rd_en, "read and write overlap")
    `BSLM_ASSERT_NOW(a_write_on_accept, mem_ctl.wr_en, bind_accept, "write without bind")
    `BSLM_ASSERT_NOW(a_full_zero, out_valid && store_full, result_value == '0, "bad drop result")

endmodule
